### src/sdf_pkg.sv
package sdf_pkg;

    localparam int DEF_SLOTS       = 4;
    localparam int DEF_FRAME_BYTES = 32;
    localparam int MAX_SLOTS       = 4;

    localparam logic [7:0] PAD_ID  = 8'hFF;
    localparam logic [7:0] NULL_ID = 8'h00;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_EN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_EN     = 3'd5;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_OVERRUN = 2'd2
    } t_kind;

    typedef struct packed {
        logic       hit;
        logic [1:0] slot;
    } t_match;

    typedef struct packed {
        logic unknown_en;
        logic all_en;
    } t_handler_en;

endpackage

### src/sdf_slot_match.sv
module sdf_slot_match
    import sdf_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [7:0]           i_wr_data,
    input  logic [7:0]           i_id,
    output t_match               o_match,
    output t_handler_en          o_handler_en
);

    localparam int NSLOT = (SLOTS < MAX_SLOTS) ? SLOTS : MAX_SLOTS;

    logic [7:0]  r_slot_id [NSLOT];
    t_handler_en r_handler_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NSLOT; j++) begin
                r_slot_id[j] <= PAD_ID;
            end
            r_handler_en <= '0;
        end else if (i_wr) begin
            for (int j = 0; j < NSLOT; j++) begin
                if (i_wr_index == CFG_IDX_W'(j)) begin
                    r_slot_id[j] <= i_wr_data;
                end
            end
            if (i_wr_index == CFG_UNKNOWN_EN) begin
                r_handler_en.unknown_en <= i_wr_data[0];
            end
            if (i_wr_index == CFG_ALL_EN) begin
                r_handler_en.all_en <= i_wr_data[0];
            end
        end
    end

    // lowest matching slot wins
    always_comb begin
        o_match = '0;
        for (int j = NSLOT - 1; j >= 0; j--) begin
            if (r_slot_id[j] == i_id) begin
                o_match.hit  = 1'b1;
                o_match.slot = 2'(j);
            end
        end
    end

    assign o_handler_en = r_handler_en;

endmodule

### src/subrecord_rx_deframer_core.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_ready         i_data_byte, i_frame_len
// result    out        o_valid / i_ready         o_kind .. o_record_end
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while o_ready is high; its result (if any) appears
// in the output register in the cycle after the byte is accepted.
// o_ready drops only while a held result waits on i_ready.
// Synchronous active-low reset; config is always ready.
module subrecord_rx_deframer_core
    import sdf_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic [5:0]           i_frame_len,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_program_id,
    output logic [4:0]           o_record_len,
    output logic [7:0]           o_payload_byte,
    output logic [4:0]           o_data_index,
    output logic                 o_slot_hit,
    output logic [1:0]           o_slot_index,
    output logic                 o_to_unknown,
    output logic                 o_to_all,
    output logic                 o_record_end,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    typedef enum logic [1:0] {
        PH_ID   = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SKIP = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] program_id;
        logic [4:0] record_len;
        logic [7:0] payload_byte;
        logic [4:0] data_index;
        logic       slot_hit;
        logic [1:0] slot_index;
        logic       to_unknown;
        logic       to_all;
        logic       record_end;
    } t_result;

    localparam logic [5:0] FRAME_MAX = 6'(FRAME_BYTES);

    t_phase      r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [7:0]  r_id, n_id;
    logic [4:0]  r_len, n_len;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_hit, n_hit;
    logic [1:0]  r_slot, n_slot;
    logic        r_out_valid;
    t_result     r_out, n_out;
    logic        n_emit;

    t_match      match;
    t_handler_en handler_en;

    logic        accept;
    logic        bad_len;
    logic        restart;
    logic [5:0]  pos;
    logic        last;
    t_phase      phase;
    logic [8:0]  len_end;
    logic [5:0]  cnt_inc;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign accept      = i_valid && o_ready;

    sdf_slot_match #(
        .SLOTS(SLOTS)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (i_cfg_valid && o_cfg_ready),
        .i_wr_index  (i_cfg_index),
        .i_wr_data   (i_cfg_data),
        .i_id        (i_data_byte),
        .o_match     (match),
        .o_handler_en(handler_en)
    );

    always_comb begin
        bad_len = (i_frame_len == 6'd0) || (i_frame_len > FRAME_MAX);
        restart = (r_pos >= i_frame_len);
        pos     = restart ? 6'd0 : r_pos;
        phase   = restart ? PH_ID : r_phase;
        last    = ((pos + 6'd1) == i_frame_len);
        len_end = {3'b000, pos} + {1'b0, i_data_byte};
        cnt_inc = {1'b0, r_cnt} + 6'd1;

        n_phase = phase;
        n_pos   = r_pos;
        n_id    = r_id;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_hit   = r_hit;
        n_slot  = r_slot;
        n_emit  = 1'b0;

        n_out              = '0;
        n_out.program_id   = r_id;
        n_out.slot_hit     = r_hit;
        n_out.slot_index   = r_slot;
        n_out.to_unknown   = !r_hit && handler_en.unknown_en;
        n_out.to_all       = handler_en.all_en;

        case (phase)
            PH_ID: begin
                if (i_data_byte != NULL_ID && i_data_byte != PAD_ID) begin
                    n_id   = i_data_byte;
                    n_hit  = match.hit;
                    n_slot = match.slot;
                    if (last) begin
                        n_emit           = 1'b1;
                        n_out            = '0;
                        n_out.kind       = KIND_OVERRUN;
                        n_out.program_id = i_data_byte;
                        n_out.record_end = 1'b1;
                        n_phase          = PH_SKIP;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                n_emit = 1'b1;
                if (len_end < {3'b000, i_frame_len}) begin
                    n_len            = i_data_byte[4:0];
                    n_cnt            = 5'd0;
                    n_out.kind       = KIND_HEADER;
                    n_out.record_len = i_data_byte[4:0];
                    n_out.record_end = (i_data_byte == 8'd0);
                    n_phase          = (i_data_byte == 8'd0) ? PH_ID : PH_DATA;
                end else begin
                    n_out            = '0;
                    n_out.kind       = KIND_OVERRUN;
                    n_out.program_id = r_id;
                    n_out.record_end = 1'b1;
                    n_phase          = PH_SKIP;
                end
            end
            PH_DATA: begin
                n_emit             = 1'b1;
                n_out.kind         = KIND_DATA;
                n_out.record_len   = r_len;
                n_out.payload_byte = i_data_byte;
                n_out.data_index   = r_cnt;
                n_out.record_end   = (cnt_inc >= {1'b0, r_len});
                n_cnt              = cnt_inc[4:0];
                if (cnt_inc[4:0] >= r_len) begin
                    n_phase = PH_ID;
                end
            end
            default: begin
            end
        endcase

        if (last) begin
            n_pos   = 6'd0;
            n_phase = PH_ID;
        end else begin
            n_pos = pos + 6'd1;
        end

        if (bad_len) begin
            n_phase = PH_ID;
            n_pos   = 6'd0;
            n_id    = r_id;
            n_len   = r_len;
            n_cnt   = r_cnt;
            n_hit   = r_hit;
            n_slot  = r_slot;
            n_emit  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ID;
            r_pos       <= '0;
            r_id        <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_id    <= n_id;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
                r_hit   <= n_hit;
                r_slot  <= n_slot;
            end
            if (accept) begin
                r_out_valid <= n_emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_program_id   = r_out.program_id;
    assign o_record_len   = r_out.record_len;
    assign o_payload_byte = r_out.payload_byte;
    assign o_data_index   = r_out.data_index;
    assign o_slot_hit     = r_out.slot_hit;
    assign o_slot_index   = r_out.slot_index;
    assign o_to_unknown   = r_out.to_unknown;
    assign o_to_all       = r_out.to_all;
    assign o_record_end   = r_out.record_end;

endmodule

### test/tb_subrecord_rx_deframer_core.sv
`timescale 1ns / 1ps

module tb_subrecord_rx_deframer_core;
    import sdf_pkg::*;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASES           = 8;
    localparam int BYTES_PER_PHASE  = 170;

    typedef enum logic [1:0] {SEEK_ID, READ_LEN, READ_DATA, SKIP_REST} t_parse_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] program_id;
        logic [4:0] record_len;
        logic [7:0] payload_byte;
        logic [4:0] data_index;
        logic       slot_hit;
        logic [1:0] slot_index;
        logic       to_unknown;
        logic       to_all;
        logic       record_end;
    } t_rx_result;

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] flen;
        logic       typed;
        logic       has_result;
        t_rx_result res;
    } t_frame_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [7:0]           i_data_byte = 8'h00;
    logic [5:0]           i_frame_len = 6'd0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [1:0]           o_kind;
    logic [7:0]           o_program_id;
    logic [4:0]           o_record_len;
    logic [7:0]           o_payload_byte;
    logic [4:0]           o_data_index;
    logic                 o_slot_hit;
    logic [1:0]           o_slot_index;
    logic                 o_to_unknown;
    logic                 o_to_all;
    logic                 o_record_end;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_ID_0;
    logic [7:0]           i_cfg_data = 8'h00;

    subrecord_rx_deframer_core DUT (.*);

    // shadow of the block's registers and parser state
    logic [7:0]   slot_id [MAX_SLOTS] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    logic         unknown_on = 1'b0;
    logic         all_on = 1'b0;
    logic [5:0]   rx_pos = 6'd0;
    t_parse_phase rx_phase = SEEK_ID;
    logic [7:0]   rec_id = 8'h00;
    logic [4:0]   rec_len = 5'd0;
    logic [4:0]   data_cnt = 5'd0;
    logic         hit_flag = 1'b0;
    logic [1:0]   hit_slot = 2'd0;

    t_rx_result deframed_q [$];
    int         mismatches = 0;
    int         bytes_sent = 0;
    bit         src_idle_on = 1'b1;
    bit         sink_idle_on = 1'b1;
    bit         quiet = 1'b0;
    bit         hold_results = 1'b0;

    t_frame_row directed_rows [24] = '{
        '{8'h5A, 6'd1,  1'b1, 1'b1,
          '{KIND_OVERRUN, 8'h5A, 5'd0, 8'h00, 5'd0, 1'b0, 2'd0, 1'b0, 1'b0, 1'b1}},
        '{8'h33, 6'd0,  1'b1, 1'b0, '0},
        '{8'hFF, 6'd63, 1'b1, 1'b0, '0},
        '{8'h00, 6'd33, 1'b1, 1'b0, '0},
        '{8'h00, 6'd32, 1'b0, 1'b0, '0},
        '{8'hFF, 6'd32, 1'b0, 1'b0, '0},
        '{8'h01, 6'd32, 1'b0, 1'b0, '0},
        '{8'h00, 6'd32, 1'b1, 1'b1,
          '{KIND_HEADER, 8'h01, 5'd0, 8'h00, 5'd0, 1'b1, 2'd1, 1'b0, 1'b1, 1'b1}},
        '{8'hFE, 6'd32, 1'b0, 1'b0, '0},
        '{8'h02, 6'd32, 1'b1, 1'b1,
          '{KIND_HEADER, 8'hFE, 5'd2, 8'h00, 5'd0, 1'b1, 2'd3, 1'b0, 1'b1, 1'b0}},
        '{8'hFF, 6'd32, 1'b0, 1'b0, '0},
        '{8'h00, 6'd32, 1'b0, 1'b0, '0},
        '{8'h77, 6'd32, 1'b0, 1'b0, '0},
        '{8'h1E, 6'd32, 1'b1, 1'b1,
          '{KIND_OVERRUN, 8'h77, 5'd0, 8'h00, 5'd0, 1'b0, 2'd0, 1'b0, 1'b0, 1'b1}},
        '{8'h5A, 6'd5,  1'b0, 1'b0, '0},
        '{8'h03, 6'd5,  1'b0, 1'b0, '0},
        '{8'hAB, 6'd5,  1'b0, 1'b0, '0},
        '{8'hCD, 6'd5,  1'b0, 1'b0, '0},
        '{8'hEF, 6'd5,  1'b0, 1'b0, '0},
        '{8'h42, 6'd2,  1'b0, 1'b0, '0},
        '{8'h01, 6'd2,  1'b1, 1'b1,
          '{KIND_OVERRUN, 8'h42, 5'd0, 8'h00, 5'd0, 1'b0, 2'd0, 1'b0, 1'b0, 1'b1}},
        '{8'h77, 6'd3,  1'b0, 1'b0, '0},
        '{8'h00, 6'd3,  1'b1, 1'b1,
          '{KIND_HEADER, 8'h77, 5'd0, 8'h00, 5'd0, 1'b0, 2'd0, 1'b1, 1'b1, 1'b1}},
        '{8'h99, 6'd3,  1'b1, 1'b1,
          '{KIND_OVERRUN, 8'h99, 5'd0, 8'h00, 5'd0, 1'b0, 2'd0, 1'b0, 1'b0, 1'b1}}
    };

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("subrecord_rx_deframer_core regression: fail");
        $finish;
    end

    function automatic t_rx_result record_out(t_kind k, logic [4:0] len, logic [7:0] pay,
                                              logic [4:0] idx, bit flags, bit ends);
        t_rx_result r;
        r.kind         = k;
        r.program_id   = rec_id;
        r.record_len   = len;
        r.payload_byte = pay;
        r.data_index   = idx;
        r.slot_hit     = flags ? hit_flag : 1'b0;
        r.slot_index   = flags ? hit_slot : 2'd0;
        r.to_unknown   = flags && !hit_flag && unknown_on;
        r.to_all       = flags && all_on;
        r.record_end   = ends;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic [5:0] flen,
                                output bit produced, output t_rx_result r);
        int pos;
        bit last_byte;
        produced = 1'b0;
        r = '0;
        if (flen == 0 || flen > DEF_FRAME_BYTES) begin
            rx_pos   = 6'd0;
            rx_phase = SEEK_ID;
            return;
        end
        if (rx_pos >= flen) begin
            rx_pos   = 6'd0;
            rx_phase = SEEK_ID;
        end
        pos = rx_pos;
        last_byte = (pos + 1 == flen);
        case (rx_phase)
            SEEK_ID: begin
                if (b != NULL_ID && b != PAD_ID) begin
                    rec_id   = b;
                    hit_flag = 1'b0;
                    hit_slot = 2'd0;
                    for (int j = 0; j < DEF_SLOTS && j < MAX_SLOTS; j++) begin
                        if (slot_id[j] == b) begin
                            hit_flag = 1'b1;
                            hit_slot = 2'(j);
                            break;
                        end
                    end
                    if (last_byte) begin
                        produced = 1'b1;
                        r = record_out(KIND_OVERRUN, 5'd0, 8'h00, 5'd0, 1'b0, 1'b1);
                        rx_phase = SKIP_REST;
                    end else begin
                        rx_phase = READ_LEN;
                    end
                end
            end
            READ_LEN: begin
                produced = 1'b1;
                if (pos + int'(b) < int'(flen)) begin
                    rec_len  = b[4:0];
                    data_cnt = 5'd0;
                    r = record_out(KIND_HEADER, rec_len, 8'h00, 5'd0, 1'b1, b == 8'h00);
                    rx_phase = (b == 8'h00) ? SEEK_ID : READ_DATA;
                end else begin
                    r = record_out(KIND_OVERRUN, 5'd0, 8'h00, 5'd0, 1'b0, 1'b1);
                    rx_phase = SKIP_REST;
                end
            end
            READ_DATA: begin
                produced = 1'b1;
                r = record_out(KIND_DATA, rec_len, b, data_cnt, 1'b1,
                               int'(data_cnt) + 1 >= int'(rec_len));
                data_cnt = data_cnt + 5'd1;
                if (data_cnt >= rec_len)
                    rx_phase = SEEK_ID;
            end
            default: ;
        endcase
        if (last_byte) begin
            rx_pos   = 6'd0;
            rx_phase = SEEK_ID;
        end else begin
            rx_pos = 6'(pos + 1);
        end
    endtask

    // caller is at a rising edge; returns at the edge that took the request
    task automatic offer_byte(input logic [7:0] b, input logic [5:0] flen,
                              input bit typed = 1'b0, input bit typed_has = 1'b0,
                              input t_rx_result typed_res = '0);
        bit         produced;
        t_rx_result r;
        int         gap;
        if (src_idle_on && !quiet && !hold_results && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_frame_len <= flen;
        do @(posedge i_clk); while (!o_ready);
        deframe_byte(b, flen, produced, r);
        if (typed) begin
            produced = typed_has;
            r = typed_res;
        end
        if (produced)
            deframed_q.push_back(r);
        if (flen != 0 && flen <= DEF_FRAME_BYTES)
            bytes_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ID_0:       slot_id[0] = val;
            CFG_ID_1:       slot_id[1] = val;
            CFG_ID_2:       slot_id[2] = val;
            CFG_ID_3:       slot_id[3] = val;
            CFG_UNKNOWN_EN: unknown_on = val[0];
            CFG_ALL_EN:     all_on = val[0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] id0, id1, id2, id3, input bit unk, all_en);
        settle();
        write_reg(CFG_ID_0, id0);
        write_reg(CFG_ID_1, id1);
        write_reg(CFG_ID_2, id2);
        write_reg(CFG_ID_3, id3);
        write_reg(CFG_UNKNOWN_EN, {7'd0, unk});
        write_reg(CFG_ALL_EN, {7'd0, all_en});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_id();
        logic [7:0] v;
        v = slot_id[$urandom_range(0, MAX_SLOTS - 1)];
        if ($urandom_range(0, 1) == 0 || v == NULL_ID || v == PAD_ID)
            v = 8'($urandom_range(1, 254));
        return v;
    endfunction

    // mostly well-formed frames; some cut short, some followed by a bad size, some noise
    task automatic send_frame();
        logic [7:0] frame_q [$];
        int         flen, pos, room, len, n, mode, cut;
        mode = $urandom_range(0, 9);
        case ($urandom_range(0, 7))
            0, 1:    flen = $urandom_range(1, 4);
            2:       flen = DEF_FRAME_BYTES;
            default: flen = $urandom_range(1, DEF_FRAME_BYTES);
        endcase
        if (mode == 9) begin
            flen = $urandom_range(0, 63);
            n = (flen >= 1 && flen <= DEF_FRAME_BYTES) ? flen : $urandom_range(1, 3);
            repeat (n) offer_byte(8'($urandom), 6'(flen));
            return;
        end
        pos = 0;
        while (pos < flen) begin
            if ($urandom_range(0, 9) == 0) begin
                frame_q.push_back($urandom_range(0, 1) ? PAD_ID : NULL_ID);
                pos++;
            end else begin
                frame_q.push_back(pick_id());
                pos++;
                if (pos < flen) begin
                    room = flen - pos - 1;
                    if ($urandom_range(0, 9) == 0)
                        len = $urandom_range(room + 1, 255);
                    else
                        len = $urandom_range(0, room);
                    frame_q.push_back(8'(len));
                    pos++;
                    n = (len > room) ? flen - pos : len;
                    repeat (n) frame_q.push_back(8'($urandom));
                    pos += n;
                end
            end
        end
        if (mode >= 7) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
        foreach (frame_q[k]) offer_byte(frame_q[k], 6'(flen));
        if (mode == 8)
            offer_byte(8'($urandom), $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63)));
    endtask

    task automatic check_field(input string name, input logic [7:0] expv, gotv);
        if (expv !== gotv) begin
            $display("%0t: %s expected %0h got %0h", $time, name, expv, gotv);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_rx_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (deframed_q.size() == 0) begin
                $display("%0t: unexpected result, expected none got kind %0d id %0h",
                         $time, o_kind, o_program_id);
                mismatches++;
            end else begin
                want = deframed_q.pop_front();
                check_field("kind", 8'(want.kind), 8'(o_kind));
                check_field("program_id", want.program_id, o_program_id);
                check_field("record_len", 8'(want.record_len), 8'(o_record_len));
                check_field("payload_byte", want.payload_byte, o_payload_byte);
                check_field("data_index", 8'(want.data_index), 8'(o_data_index));
                check_field("slot_hit", 8'(want.slot_hit), 8'(o_slot_hit));
                check_field("slot_index", 8'(want.slot_index), 8'(o_slot_index));
                check_field("to_unknown", 8'(want.to_unknown), 8'(o_to_unknown));
                check_field("to_all", 8'(want.to_all), 8'(o_to_all));
                check_field("record_end", 8'(want.record_end), 8'(o_record_end));
            end
        end
    end

    initial begin : result_sink
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge i_clk);
                hold_results = 1'b0;
                i_ready <= 1'b1;
            end else if (sink_idle_on && !quiet && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 16);
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] cfg_ids [MAX_SLOTS];
        int         r, w;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_config(8'h5A, 8'h01, 8'h01, 8'hFE, 1'b1, 1'b1);
        foreach (directed_rows[k])
            offer_byte(directed_rows[k].data, directed_rows[k].flen, directed_rows[k].typed,
                       directed_rows[k].has_result, directed_rows[k].res);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_config(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
                1: load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
                default: begin
                    for (int j = 0; j < MAX_SLOTS; j++) begin
                        r = $urandom_range(0, 7);
                        if (r == 0)
                            cfg_ids[j] = PAD_ID;
                        else if (r == 1)
                            cfg_ids[j] = NULL_ID;
                        else if (r == 2 && j > 0)
                            cfg_ids[j] = cfg_ids[0];
                        else
                            cfg_ids[j] = 8'($urandom_range(1, 254));
                    end
                    load_config(cfg_ids[0], cfg_ids[1], cfg_ids[2], cfg_ids[3],
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            endcase
            quiet        = (phase == PHASES - 1);
            src_idle_on  = ($urandom_range(0, 2) != 0);
            sink_idle_on = ($urandom_range(0, 2) != 0);
            if (phase == 2)
                hold_results = 1'b1;
            bytes_sent = 0;
            while (bytes_sent < BYTES_PER_PHASE) send_frame();
        end

        i_valid <= 1'b0;
        for (w = 0; w < 5000 && deframed_q.size() != 0; w++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (deframed_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, deframed_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("subrecord_rx_deframer_core regression: pass");
        else
            $display("subrecord_rx_deframer_core regression: fail");
        $finish;
    end

endmodule

### subrecord_rx_deframer_core.f
src/sdf_pkg.sv
src/sdf_slot_match.sv
src/subrecord_rx_deframer_core.sv
test/tb_subrecord_rx_deframer_core.sv
